// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer: command codes,
// control characters, the per-command plan and the sequencer states
// ----------------------------------------------------------------------------
package tcw_pkg;

   // command codes
   localparam logic [1:0] CMD_PRINT = 2'd0;
   localparam logic [1:0] CMD_MOVE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // control characters
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

   // attribute of a blank cell after reset, and the reset value of the register
   localparam logic [7:0] RESET_ATTR = 8'd7;

   // cell layout: character in the low byte, attribute in the high byte
   localparam int CELL_W = 16;

   // what one command needs from the cell store
   typedef struct packed {
      logic write_cell; // one cell write at the command's address
      logic blank;      // the written cell is blank rather than the character
      logic scroll;     // grid moves up one row afterwards
      logic clear;      // every cell is blanked
      logic read;       // one cell read at the command's address
   } plan_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_COPY   = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

endpackage

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// cursor registers and per-command decode: next cursor, cell address, plan
// ----------------------------------------------------------------------------
module tcw_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int COL_W   = $clog2(COLUMNS),
   parameter int ROW_W   = $clog2(ROWS),
   parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_cmd,
   input  logic [7:0]            req_char_code,
   input  logic [6:0]            req_new_x,
   input  logic [4:0]            req_new_y,
   input  logic                  commit,
   output tcw_pkg::plan_type     plan,
   output logic [ADDR_W-1:0]     cell_addr,
   output logic [COL_W-1:0]      col,
   output logic [ROW_W-1:0]      row,
   output logic [ADDR_W-1:0]     position
);

   import tcw_pkg::*;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [COL_W-1:0]  col_ff, col_in, x_clamp;
   logic [ROW_W-1:0]  row_ff, row_in, y_clamp;
   logic [ADDR_W-1:0] pos_cur, pos_pick;

   always_comb begin
      pos_cur  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
      x_clamp  = (32'(req_new_x) > COLUMNS - 1) ? LAST_COL : COL_W'(req_new_x);
      y_clamp  = (32'(req_new_y) > ROWS - 1) ? LAST_ROW : ROW_W'(req_new_y);
      pos_pick = ADDR_W'(y_clamp) * ADDR_W'(COLUMNS) + ADDR_W'(x_clamp);
   end

   always_comb begin
      plan      = '0;
      col_in    = col_ff;
      row_in    = row_ff;
      cell_addr = pos_cur;
      case (req_cmd)
         CMD_PRINT: begin
            if (req_char_code == CHAR_NEWLINE) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  plan.scroll = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (req_char_code == CHAR_BACKSPACE) begin
               // step back one cell, top-left corner stays put
               plan.write_cell = 1'b1;
               plan.blank      = 1'b1;
               cell_addr       = (pos_cur == '0) ? '0 : pos_cur - 1'b1;
               if (col_ff == '0) begin
                  if (row_ff != '0) begin
                     col_in = LAST_COL;
                     row_in = row_ff - 1'b1;
                  end
               end else begin
                  col_in = col_ff - 1'b1;
               end
            end else begin
               plan.write_cell = 1'b1;
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  if (row_ff == LAST_ROW) begin
                     plan.scroll = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         CMD_MOVE: begin
            col_in = x_clamp;
            row_in = y_clamp;
         end
         CMD_CLEAR: begin
            plan.clear = 1'b1;
            col_in     = '0;
            row_in     = '0;
         end
         CMD_READ: begin
            plan.read = 1'b1;
            cell_addr = pos_pick;
         end
         default: begin
            plan = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (commit) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col      = col_ff;
   assign row      = row_ff;
   assign position = pos_cur;

endmodule

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console: a grid of character cells in one ram plus a cursor;
// prints, moves the cursor, clears, and reads back single cells
// ----------------------------------------------------------------------------
// print, move and read pass the ST_RESULT state and give a registered result;
//   a new command is taken only once that result is loaded into the output register
// a scroll moves the grid up one row through the single ram port pair, one cell
//   a cycle, then blanks the bottom row; a clear blanks all COLUMNS*ROWS cells
// reset: cursor homes, attribute goes to 7, then a clearing pass over all
//   COLUMNS*ROWS cells (2000 at 80x25) blanks the ram before the first command
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   // command channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_char_code,
   input  logic [6:0] req_new_x,
   input  logic [4:0] req_new_y,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_cursor_x,
   output logic [4:0] rsp_cursor_y,
   output logic [10:0] rsp_cursor_position,
   output logic       rsp_scrolled,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attr,
   // attribute register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_text_attribute
);

   import tcw_pkg::*;

   localparam int NUM_CELLS = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(NUM_CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(NUM_CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(NUM_CELLS - COLUMNS);

   state_type state_ff, state_in;

   // fill pointer (reset pass, clear, bottom row of a scroll)
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   // scroll copy: source read address, and the pending write in the cycle after the read
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic              copy_pend_ff, copy_pend_in;

   logic              scroll_ff, scroll_in;
   logic              read_ff, read_in;
   logic [7:0]        attr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [6:0]        rsp_x_ff;
   logic [4:0]        rsp_y_ff;
   logic [10:0]       rsp_pos_ff;
   logic              rsp_scrolled_ff;
   logic [7:0]        rsp_char_ff;
   logic [7:0]        rsp_attr_ff;
   logic              rsp_load;
   logic              rsp_free;

   logic              accept;
   plan_type          plan;
   logic [ADDR_W-1:0] cell_addr;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [ADDR_W-1:0] cur_pos;

   // ram ports
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;
   logic [CELL_W-1:0]    blank_cell;

   // commands are only taken between operations
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   // output register can take a new result this cycle
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign blank_cell = {attr_ff, 8'h00};

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_new_x     (req_new_x),
      .req_new_y     (req_new_y),
      .commit        (accept),
      .plan          (plan),
      .cell_addr     (cell_addr),
      .col           (cur_col),
      .row           (cur_row),
      .position      (cur_pos)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NUM_CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer and ram port control
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      src_in       = src_ff;
      dst_in       = src_ff - ROW_STRIDE;
      copy_pend_in = (state_ff == ST_COPY);
      scroll_in    = scroll_ff;
      read_in      = read_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = blank_cell;
      ram_re       = 1'b0;
      ram_raddr    = cell_addr;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // clearing pass after reset, always with the reset attribute
            ram_we    = 1'b1;
            ram_wdata = {RESET_ATTR, 8'h00};
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               scroll_in = plan.scroll;
               read_in   = plan.read;
               if (plan.write_cell) begin
                  ram_we    = 1'b1;
                  ram_waddr = cell_addr;
                  ram_wdata = {attr_ff, plan.blank ? 8'h00 : req_char_code};
               end
               ram_re = plan.read;
               if (plan.scroll) begin
                  src_in   = ROW_STRIDE;
                  state_in = ST_COPY;
               end else if (plan.clear) begin
                  ptr_in   = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_COPY: begin
            // read one row below, write it back one row up in the following cycle
            ram_re    = 1'b1;
            ram_raddr = src_ff;
            if (src_ff == LAST_CELL) begin
               ptr_in   = BOTTOM_ROW;
               state_in = ST_FILL;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         ST_FILL: begin
            // the last copy write goes first
            if (!copy_pend_ff) begin
               ram_we = 1'b1;
               if (ptr_ff == LAST_CELL) begin
                  state_in = ST_RESULT;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (copy_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = dst_ff;
         ram_wdata = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         copy_pend_ff <= 1'b0;
         scroll_ff    <= 1'b0;
         read_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         copy_pend_ff <= copy_pend_in;
         scroll_ff    <= scroll_in;
         read_ff      <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

   // attribute register, writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_text_attribute;
      end
   end

   // result register: loaded when the previous result is gone or leaving
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff        <= 7'(cur_col);
         rsp_y_ff        <= 5'(cur_row);
         rsp_pos_ff      <= 11'(cur_pos);
         rsp_scrolled_ff <= scroll_ff;
         rsp_char_ff     <= read_ff ? ram_rdata[7:0] : 8'h00;
         rsp_attr_ff     <= read_ff ? ram_rdata[15:8] : 8'h00;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_x        = rsp_x_ff;
   assign rsp_cursor_y        = rsp_y_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_attr       = rsp_attr_ff;

endmodule

// ===== design/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on the result channel of the text console writer
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_cursor_x,
   input logic [4:0]  rsp_cursor_y,
   input logic [10:0] rsp_cursor_position,
   input logic        rsp_scrolled
);

   // result stays valid and its position stable while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_position))
      else $error("result dropped or changed under stall");

   // linear position matches the reported column and row
   a_rsp_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_position ==
         11'(32'(rsp_cursor_y) * COLUMNS + 32'(rsp_cursor_x)))
      else $error("cursor position does not match column and row");

   // cursor stays inside the grid
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_x) < COLUMNS && 32'(rsp_cursor_y) < ROWS)
      else $error("cursor outside the grid");

   // a scroll leaves the cursor at the start of the bottom row
   a_rsp_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_x == 7'd0 &&
         rsp_cursor_y == 5'(ROWS - 1))
      else $error("scroll left the cursor off the bottom row start");

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_cursor_x        (rsp_cursor_x),
   .rsp_cursor_y        (rsp_cursor_y),
   .rsp_cursor_position (rsp_cursor_position),
   .rsp_scrolled        (rsp_scrolled)
);
